// ----- rtl/core/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and the UTF-8 encoder for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Parser phases
  localparam logic [2:0] PH_TEXT     = 3'd0;
  localparam logic [2:0] PH_ESC      = 3'd1;
  localparam logic [2:0] PH_HEX1     = 3'd2;
  localparam logic [2:0] PH_HIGH     = 3'd3;
  localparam logic [2:0] PH_HIGH_ESC = 3'd4;
  localparam logic [2:0] PH_HEX2     = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_TRUNC_ESC = 3'd0;
  localparam logic [2:0] ERR_UNK_ESC   = 3'd1;
  localparam logic [2:0] ERR_TRUNC_HEX = 3'd2;
  localparam logic [2:0] ERR_BAD_HEX   = 3'd3;
  localparam logic [2:0] ERR_CTRL      = 3'd4;
  localparam logic [2:0] ERR_UNTERM    = 3'd5;

  localparam logic [20:0] CP_REPLACE   = 21'h00FFFD;
  localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
  localparam logic [5:0]  HIGH_TAG     = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0]  LOW_TAG      = 6'b110111;  // 0xDC00..0xDFFF
  localparam logic [7:0]  CH_QUOTE     = 8'h22;
  localparam logic [7:0]  CH_BSLASH    = 8'h5C;
  localparam logic [7:0]  CH_U         = 8'h75;
  localparam logic [7:0]  CH_SPACE     = 8'h20;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] hex_accum;
    logic [9:0]  high_unit;
    logic [1:0]  digit_count;
    logic        hex_bad;
  } st_t;

  localparam st_t ST_RESET = '{phase: PH_TEXT, hex_accum: 16'd0, high_unit: 10'd0,
                               digit_count: 2'd0, hex_bad: 1'b0};

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] code;
  } res_t;

  // All results caused by one input item, in order
  typedef struct packed {
    logic [2:0]       cnt;
    res_t [3:0]       res;
  } bundle_t;

  typedef struct packed {
    logic [2:0]       n;
    logic [3:0][7:0]  b;
  } utf8_t;

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.n    = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      e.n    = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.n    = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.n    = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

// ----- rtl/core/jsu_decode.sv -----
// ----------------------------------------------------------------------------
// jsu_decode
// Next-state and result bundle for one input byte or end marker.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  jsu_pkg::st_t     st_i,
  input  logic [7:0]       byte_i,
  input  logic             is_end_i,
  output jsu_pkg::st_t     st_o,
  output jsu_pkg::bundle_t bundle_o
);
  import jsu_pkg::*;

  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [15:0] acc_new;
  logic        bad_new;
  logic        grp_last;
  logic        esc_ok;
  logic [7:0]  esc_val;
  // plain-text outcome
  res_t        pb_tail;
  logic        pb_tail_v;
  logic [2:0]  pb_phase;
  logic        pb_rst;
  // escape-letter outcome (letter u handled by caller)
  res_t        es_tail;
  logic        es_rst;
  // assembly
  st_t         n;
  logic        rst;
  logic        u_en;
  logic [20:0] u_cp;
  logic        tail_v;
  res_t        tail;
  utf8_t       enc;
  logic [2:0]  u_n;

  // hex digit value; letters take low nibble + 9
  always_comb begin
    hex_ok = 1'b0;
    hex_d  = 4'd0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      hex_ok = 1'b1;
      hex_d  = byte_i[3:0];
    end else if ((byte_i >= 8'h61 && byte_i <= 8'h66) ||
                 (byte_i >= 8'h41 && byte_i <= 8'h46)) begin
      hex_ok = 1'b1;
      hex_d  = byte_i[3:0] + 4'd9;
    end
  end

  assign acc_new  = {st_i.hex_accum[11:0], hex_d};
  assign bad_new  = st_i.hex_bad | ~hex_ok;
  assign grp_last = (st_i.digit_count == 2'd3);

  always_comb begin
    esc_ok  = 1'b1;
    esc_val = byte_i;
    case (byte_i)
      8'h22, 8'h5C, 8'h2F: esc_val = byte_i;
      8'h62:               esc_val = 8'h08;
      8'h66:               esc_val = 8'h0C;
      8'h6E:               esc_val = 8'h0A;
      8'h72:               esc_val = 8'h0D;
      8'h74:               esc_val = 8'h09;
      default:             esc_ok  = 1'b0;
    endcase
  end

  always_comb begin
    es_tail = '0;
    es_rst  = 1'b0;
    if (esc_ok) begin
      es_tail.data = esc_val;
    end else begin
      es_tail.kind = KIND_ERR;
      es_tail.code = ERR_UNK_ESC;
      es_rst       = 1'b1;
    end
  end

  always_comb begin
    pb_tail   = '0;
    pb_tail_v = 1'b1;
    pb_phase  = PH_TEXT;
    pb_rst    = 1'b0;
    if (byte_i == CH_QUOTE) begin
      pb_tail.kind = KIND_DONE;
      pb_rst       = 1'b1;
    end else if (byte_i == CH_BSLASH) begin
      pb_tail_v = 1'b0;
      pb_phase  = PH_ESC;
    end else if (byte_i < CH_SPACE) begin
      pb_tail.kind = KIND_ERR;
      pb_tail.code = ERR_CTRL;
      pb_rst       = 1'b1;
    end else begin
      pb_tail.data = byte_i;
    end
  end

  always_comb begin
    n      = st_i;
    rst    = 1'b0;
    u_en   = 1'b0;
    u_cp   = CP_REPLACE;
    tail_v = 1'b0;
    tail   = '0;
    if (is_end_i) begin
      rst       = 1'b1;
      tail_v    = 1'b1;
      tail.kind = KIND_ERR;
      unique case (st_i.phase) inside
        PH_ESC, PH_HIGH_ESC: tail.code = ERR_TRUNC_ESC;
        PH_HEX1, PH_HEX2:    tail.code = ERR_TRUNC_HEX;
        PH_HIGH: begin
          u_en      = 1'b1;
          tail.code = ERR_UNTERM;
        end
        default:             tail.code = ERR_UNTERM;
      endcase
    end else begin
      unique case (st_i.phase) inside
        PH_ESC: begin
          if (byte_i == CH_U) begin
            n.phase       = PH_HEX1;
            n.hex_accum   = 16'd0;
            n.digit_count = 2'd0;
            n.hex_bad     = 1'b0;
          end else begin
            n.phase = PH_TEXT;
            tail_v  = 1'b1;
            tail    = es_tail;
            rst     = es_rst;
          end
        end
        PH_HEX1, PH_HEX2: begin
          n.hex_accum   = acc_new;
          n.hex_bad     = bad_new;
          n.digit_count = grp_last ? 2'd0 : st_i.digit_count + 2'd1;
          if (grp_last) begin
            if (bad_new) begin
              tail_v    = 1'b1;
              tail.kind = KIND_ERR;
              tail.code = ERR_BAD_HEX;
              rst       = 1'b1;
            end else begin
              n.phase = PH_TEXT;
              if (st_i.phase == PH_HEX1) begin
                if (acc_new[15:10] == HIGH_TAG) begin
                  n.high_unit = acc_new[9:0];
                  n.phase     = PH_HIGH;
                end else begin
                  u_en = 1'b1;
                  if (acc_new[15:10] != LOW_TAG) u_cp = {5'd0, acc_new};
                end
              end else begin
                u_en = 1'b1;
                if (acc_new[15:10] == LOW_TAG)
                  u_cp = CP_SUPP_BASE + {1'b0, st_i.high_unit, acc_new[9:0]};
              end
            end
          end
        end
        PH_HIGH: begin
          if (byte_i == CH_BSLASH) begin
            n.phase = PH_HIGH_ESC;
          end else begin
            u_en    = 1'b1;
            n.phase = pb_phase;
            tail_v  = pb_tail_v;
            tail    = pb_tail;
            rst     = pb_rst;
          end
        end
        PH_HIGH_ESC: begin
          if (byte_i == CH_U) begin
            n.phase       = PH_HEX2;
            n.hex_accum   = 16'd0;
            n.digit_count = 2'd0;
            n.hex_bad     = 1'b0;
          end else begin
            u_en    = 1'b1;
            n.phase = PH_TEXT;
            tail_v  = 1'b1;
            tail    = es_tail;
            rst     = es_rst;
          end
        end
        default: begin
          n.phase = pb_phase;
          tail_v  = pb_tail_v;
          tail    = pb_tail;
          rst     = pb_rst;
        end
      endcase
    end
    if (rst) n = ST_RESET;
  end

  assign enc = utf8_enc(u_cp);
  assign u_n = u_en ? enc.n : 3'd0;

  // encoded bytes first, then the single trailing result
  always_comb begin
    bundle_o.cnt = u_n + {2'd0, tail_v};
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < u_n) begin
        bundle_o.res[i].data = enc.b[i];
        bundle_o.res[i].kind = KIND_DATA;
        bundle_o.res[i].code = ERR_TRUNC_ESC;
      end else begin
        bundle_o.res[i] = tail;
      end
    end
  end

  assign st_o = n;

endmodule

// ----- rtl/core/json_string_unescape_top.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape_top
// JSON string body unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// Takes one byte of a JSON string body (opening quote already removed) per
// transfer, or an end marker, and returns decoded UTF-8 bytes followed by a
// done or error result. An input transfer is taken every cycle as long as
// each one causes at most one result and out_ready keeps up; a transfer
// that causes k results (a \u escape or surrogate pair can give up to four)
// holds the output until all k are sent. The parser state is updated in the
// cycle of the input transfer, and the whole result group of that transfer
// is written into a two-entry result queue, so results are registered before
// they appear and the input stays open while a result waits on out_ready.
// in_ready drops only when both queue entries hold results not yet fully
// sent. Transfers that cause no result (a backslash, a hex digit inside a
// group) write nothing. out_last marks the final result of each input
// transfer; done and error results are always last. After done or error
// the parser is back in plain text.
// ----------------------------------------------------------------------------
module json_string_unescape_top (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_is_end,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic [2:0] out_error_code,
  output logic       out_last
);
  import jsu_pkg::*;

  // parser state, advanced on each input transfer
  st_t        st_r;
  st_t        st_nxt;
  bundle_t    dec_bundle;

  // result queue: one entry holds every result of one input transfer
  bundle_t    q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] q_cnt_r;
  logic [1:0] q_cnt_nxt;
  logic [1:0] idx_r;   // result within the head entry

  logic       in_xfer;
  logic       out_xfer;
  logic       push;
  logic       pop;
  bundle_t    head;
  res_t       cur;

  jsu_decode u_decode (
    .st_i     (st_r),
    .byte_i   (in_byte),
    .is_end_i (in_is_end),
    .st_o     (st_nxt),
    .bundle_o (dec_bundle)
  );

  assign in_ready  = (q_cnt_r != 2'd2);
  assign in_xfer   = in_valid & in_ready;
  assign push      = in_xfer & (dec_bundle.cnt != 3'd0);

  assign head      = q_r[rd_ptr_r];
  assign cur       = head.res[idx_r];
  assign out_valid = (q_cnt_r != 2'd0);
  assign out_last  = ({1'b0, idx_r} == head.cnt - 3'd1);
  assign out_xfer  = out_valid & out_ready;
  assign pop       = out_xfer & out_last;

  assign out_byte       = cur.data;
  assign out_kind       = cur.kind;
  assign out_error_code = cur.code;

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    if (push && !pop)      q_cnt_nxt = q_cnt_r + 2'd1;
    else if (pop && !push) q_cnt_nxt = q_cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_RESET;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
      idx_r    <= 2'd0;
    end else begin
      if (in_xfer) st_r <= st_nxt;
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
        idx_r    <= 2'd0;
      end else if (out_xfer) begin
        idx_r <= idx_r + 2'd1;
      end
      q_cnt_r <= q_cnt_nxt;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= dec_bundle;
  end

  // ---- assertions ----

  // done and error always close the result group of their input transfer
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DATA) |-> out_last)
    else $error("done/error result not marked last");

  // queue occupancy never exceeds its two entries
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3)
    else $error("result queue overflow");

  // a queued group always holds at least one result and at most four
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (head.cnt != 3'd0 && head.cnt <= 3'd4))
    else $error("bad result count in queue head");

  // a result group in progress stays at the head while stalled
  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(idx_r) && $stable(rd_ptr_r))
    else $error("head moved without a transfer");

endmodule

// ----- bench/json_string_unescape_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_unescape_checker
// Watches both channels of the unescaper, decodes each accepted input byte on
// its own copy of the parser and compares every result transfer in order.
// ----------------------------------------------------------------------------
module json_string_unescape_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_is_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic [1:0] out_kind,
  input  logic [2:0] out_error_code,
  input  logic       out_last,
  output int         fail_count,
  output int         pending,
  output int         results_seen,
  output int         strings_closed,
  output int         errors_seen
);
  import jsu_pkg::*;

  localparam logic [2:0] NO_CODE = 3'd0;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic [2:0] code;
    logic       last;
  } text_res_t;

  text_res_t decoded_q[$];    // results still owed by the block, oldest first
  text_res_t byte_results_q[$];

  // decoder state
  logic [2:0]  ph;
  logic [15:0] acc;
  logic [9:0]  hi_unit;
  logic [1:0]  ndig;
  logic        bad_dig;

  task automatic put_res(input logic [7:0] d, input logic [1:0] k, input logic [2:0] c);
    text_res_t r;
    r.data = d;
    r.kind = k;
    r.code = c;
    r.last = 1'b0;
    if (byte_results_q.size() < 4) byte_results_q.insert(byte_results_q.size(), r);
  endtask

  task automatic clear_parse();
    ph      = PH_TEXT;
    acc     = '0;
    hi_unit = '0;
    ndig    = '0;
    bad_dig = 1'b0;
  endtask

  task automatic raise_error(input logic [2:0] c);
    put_res(8'h00, KIND_ERR, c);
    clear_parse();
  endtask

  task automatic start_group(input logic [2:0] next_ph);
    ph      = next_ph;
    acc     = '0;
    ndig    = '0;
    bad_dig = 1'b0;
  endtask

  task automatic put_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put_res(cp[7:0], KIND_DATA, NO_CODE);
    end else if (cp < 21'h800) begin
      put_res(8'hC0 | {3'b000, cp[10:6]}, KIND_DATA, NO_CODE);
      put_res(8'h80 | {2'b00, cp[5:0]}, KIND_DATA, NO_CODE);
    end else if (cp < 21'h10000) begin
      put_res(8'hE0 | {4'b0000, cp[15:12]}, KIND_DATA, NO_CODE);
      put_res(8'h80 | {2'b00, cp[11:6]}, KIND_DATA, NO_CODE);
      put_res(8'h80 | {2'b00, cp[5:0]}, KIND_DATA, NO_CODE);
    end else begin
      put_res(8'hF0 | {5'b00000, cp[20:18]}, KIND_DATA, NO_CODE);
      put_res(8'h80 | {2'b00, cp[17:12]}, KIND_DATA, NO_CODE);
      put_res(8'h80 | {2'b00, cp[11:6]}, KIND_DATA, NO_CODE);
      put_res(8'h80 | {2'b00, cp[5:0]}, KIND_DATA, NO_CODE);
    end
  endtask

  // 16 flags a byte that is not a hex digit
  function automatic logic [4:0] nibble(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= "0" && c <= "9") t = c - "0";
    else if (c >= "a" && c <= "f") t = c - "a" + 8'd10;
    else if (c >= "A" && c <= "F") t = c - "A" + 8'd10;
    else t = 8'd16;
    return t[4:0];
  endfunction

  task automatic take_plain(input logic [7:0] c);
    if (c == CH_QUOTE) begin
      put_res(8'h00, KIND_DONE, NO_CODE);
      clear_parse();
    end else if (c == CH_BSLASH) begin
      ph = PH_ESC;
    end else if (c < CH_SPACE) begin
      raise_error(ERR_CTRL);
    end else begin
      put_res(c, KIND_DATA, NO_CODE);
    end
  endtask

  task automatic take_escape(input logic [7:0] c);
    logic [7:0] v;
    logic       emit;
    ph   = PH_TEXT;
    v    = c;
    emit = 1'b1;
    case (c)
      CH_QUOTE, CH_BSLASH, "/": v = c;
      "b": v = 8'h08;
      "f": v = 8'h0C;
      "n": v = 8'h0A;
      "r": v = 8'h0D;
      "t": v = 8'h09;
      CH_U: begin
        start_group(PH_HEX1);
        emit = 1'b0;
      end
      default: begin
        raise_error(ERR_UNK_ESC);
        emit = 1'b0;
      end
    endcase
    if (emit) put_res(v, KIND_DATA, NO_CODE);
  endtask

  // a bad digit does not stop the group; it is reported on the fourth byte
  task automatic take_digit(input logic [7:0] c, output logic group_done);
    logic [4:0] d;
    d          = nibble(c);
    group_done = 1'b0;
    if (d[4]) bad_dig = 1'b1;
    acc = {acc[11:0], d[3:0]};
    if (ndig != 2'd3) begin
      ndig = ndig + 2'd1;
    end else begin
      ndig = 2'd0;
      if (bad_dig) raise_error(ERR_BAD_HEX);
      else group_done = 1'b1;
    end
  endtask

  task automatic decode_byte(input logic [7:0] c, input logic is_end);
    logic      done;
    text_res_t r;
    byte_results_q.delete();
    if (is_end) begin
      case (ph)
        PH_ESC, PH_HIGH_ESC: raise_error(ERR_TRUNC_ESC);
        PH_HEX1, PH_HEX2:    raise_error(ERR_TRUNC_HEX);
        PH_HIGH: begin
          put_code_point(CP_REPLACE);
          raise_error(ERR_UNTERM);
        end
        default: raise_error(ERR_UNTERM);
      endcase
    end else begin
      case (ph)
        PH_ESC: take_escape(c);
        PH_HEX1: begin
          take_digit(c, done);
          if (done) begin
            ph = PH_TEXT;
            if (acc[15:10] == HIGH_TAG) begin
              hi_unit = acc[9:0];
              ph      = PH_HIGH;
            end else if (acc[15:10] == LOW_TAG) begin
              put_code_point(CP_REPLACE);
            end else begin
              put_code_point({5'b00000, acc});
            end
          end
        end
        PH_HIGH: begin
          if (c == CH_BSLASH) begin
            ph = PH_HIGH_ESC;
          end else begin
            put_code_point(CP_REPLACE);
            ph = PH_TEXT;
            take_plain(c);
          end
        end
        PH_HIGH_ESC: begin
          if (c == CH_U) begin
            start_group(PH_HEX2);
          end else begin
            put_code_point(CP_REPLACE);
            take_escape(c);
          end
        end
        PH_HEX2: begin
          take_digit(c, done);
          if (done) begin
            ph = PH_TEXT;
            if (acc[15:10] == LOW_TAG)
              put_code_point(CP_SUPP_BASE + {1'b0, hi_unit, acc[9:0]});
            else
              put_code_point(CP_REPLACE);
          end
        end
        default: begin
          ph = PH_TEXT;
          take_plain(c);
        end
      endcase
    end
    if (byte_results_q.size() > 0) begin
      r      = byte_results_q.pop_back();
      r.last = 1'b1;
      byte_results_q.insert(byte_results_q.size(), r);
    end
    foreach (byte_results_q[i]) decoded_q.insert(decoded_q.size(), byte_results_q[i]);
  endtask

  always @(posedge clk) begin : watch
    text_res_t want;
    int        bad;
    if (!rst_n) begin
      clear_parse();
      decoded_q.delete();
    end else begin
      // result side first: it can only belong to an earlier input transfer
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (out_kind == KIND_DONE) strings_closed <= strings_closed + 1;
        if (out_kind == KIND_ERR) errors_seen <= errors_seen + 1;
        if (decoded_q.size() == 0) begin
          $error("result transfer with nothing expected: byte %02h kind %0d code %0d",
                 out_byte, out_kind, out_error_code);
          fail_count <= fail_count + 1;
        end else begin
          want = decoded_q.pop_front();
          bad  = 0;
          if (out_byte !== want.data) begin
            $error("out_byte mismatch: expected %02h, actual %02h", want.data, out_byte);
            bad++;
          end
          if (out_kind !== want.kind) begin
            $error("out_kind mismatch: expected %0d, actual %0d", want.kind, out_kind);
            bad++;
          end
          if (out_error_code !== want.code) begin
            $error("out_error_code mismatch: expected %0d, actual %0d",
                   want.code, out_error_code);
            bad++;
          end
          if (out_last !== want.last) begin
            $error("out_last mismatch: expected %0d, actual %0d", want.last, out_last);
            bad++;
          end
          fail_count <= fail_count + bad;
        end
      end
      if (in_valid && in_ready) decode_byte(in_byte, in_is_end);
    end
    pending <= decoded_q.size();
  end

endmodule

// ----- bench/json_string_unescape_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_unescape_top_tb
// Drives JSON string bodies into the unescaper and reports the verdict.
// ----------------------------------------------------------------------------
// A short directed sequence hits the byte extremes, plain escapes, a 2-byte
// \u code point, a lone high surrogate, control characters, an unknown escape
// and both end-of-buffer cases. Random strings follow: mostly well-formed
// text with escapes, \u code points of every UTF-8 length and surrogate
// pairs, closed by a quote or broken on purpose, plus some raw noise.
// Prediction and comparison live in the checker instance.
// ----------------------------------------------------------------------------
module json_string_unescape_top_tb;
  import jsu_pkg::*;

  localparam int N_ITEMS      = 410;
  localparam int CYCLE_LIMIT  = 200000;  // watchdog bound, far above a normal run
  localparam int DRAIN_CYCLES = 16;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_is_end;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic [2:0] out_error_code;
  logic       out_last;

  int fail_count;
  int pending;
  int results_seen;
  int strings_closed;
  int errors_seen;

  int sent      = 0;   // input transfers completed
  int src_idle  = 37;  // percent of cycles the sender holds back
  int sink_idle = 53;  // percent of cycles the receiver stalls
  int cycles    = 0;

  // pending string: bit 8 set marks an end-of-buffer item
  logic [8:0] text_q[$];

  logic [7:0] esc_letters [8] = '{CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"};

  json_string_unescape_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_is_end     (in_is_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_kind      (out_kind),
    .out_error_code(out_error_code),
    .out_last      (out_last)
  );

  json_string_unescape_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_is_end     (in_is_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_kind      (out_kind),
    .out_error_code(out_error_code),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .pending       (pending),
    .results_seen  (results_seen),
    .strings_closed(strings_closed),
    .errors_seen   (errors_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: stall pattern follows the current idling mix.
  always @(negedge clk) begin
    out_ready <= (sink_idle == 0) || ($urandom_range(99) >= sink_idle);
  end

  // ---------------------------------------------------------------------------
  // String building
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), {1'b0, b});
  endtask

  // The byte of an end item is ignored, so it carries noise.
  task automatic add_end();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    text_q.insert(text_q.size(), {1'b1, b});
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + n;
    return ($urandom_range(1) ? "A" : "a") + n - 8'd10;
  endfunction

  // letters g..z or G..Z: never a hex digit
  function automatic logic [7:0] bad_hex_char();
    return ($urandom_range(1) ? "g" : "G") + 8'($urandom_range(19));
  endfunction

  // \uXXXX; bad_at picks one digit (0 = first) to replace, -1 for none
  task automatic add_unit(input logic [15:0] u, input int bad_at);
    add_byte(CH_BSLASH);
    add_byte(CH_U);
    for (int i = 0; i < 4; i++) begin
      if (i == bad_at) add_byte(bad_hex_char());
      else add_byte(hex_char(u[15 - 4*i -: 4]));
    end
  endtask

  // surrogate payloads lean toward the ends of their range
  function automatic logic [9:0] rand10();
    case ($urandom_range(3))
      0:       return 10'h000;
      1:       return 10'h3FF;
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  function automatic logic [15:0] rand_high();
    return 16'hD800 | {6'b0, rand10()};
  endfunction

  function automatic logic [15:0] rand_low();
    return 16'hDC00 | {6'b0, rand10()};
  endfunction

  // any non-surrogate unit, spread over the 1, 2 and 3 byte encodings
  function automatic logic [15:0] rand_bmp();
    logic [15:0] u;
    case ($urandom_range(2))
      0: u = 16'($urandom_range(16'h007F));
      1: u = 16'($urandom_range(16'h07FF, 16'h0080));
      default: begin
        do u = 16'($urandom_range(16'hFFFF, 16'h0800)); while (u[15:11] == 5'b11011);
      end
    endcase
    return u;
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(8'hFF, 8'h20)); while (b == CH_QUOTE || b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic known_escape(input logic [7:0] b);
    foreach (esc_letters[i]) if (b == esc_letters[i]) return 1'b1;
    return b == CH_U;
  endfunction

  task automatic add_body_token();
    int          pick;
    logic [15:0] u;
    pick = $urandom_range(99);
    if (pick < 40) begin
      add_byte(rand_plain());
    end else if (pick < 58) begin
      add_byte(CH_BSLASH);
      add_byte(esc_letters[3'($urandom_range(7))]);
    end else if (pick < 72) begin
      add_unit(rand_bmp(), -1);
    end else if (pick < 84) begin
      add_unit(rand_high(), -1);         // joined pair, up to U+10FFFF
      add_unit(rand_low(), -1);
    end else if (pick < 88) begin
      add_unit(rand_low(), -1);          // low unit with no high before it
    end else if (pick < 92) begin
      add_unit(rand_high(), -1);         // high unit broken by a plain byte
      add_byte(rand_plain());
    end else if (pick < 96) begin
      add_unit(rand_high(), -1);         // high unit broken by another escape
      add_byte(CH_BSLASH);
      add_byte(esc_letters[3'($urandom_range(7))]);
    end else begin
      add_unit(rand_high(), -1);         // second unit is not a low surrogate
      do u = 16'($urandom_range(16'hFFFF)); while (u[15:10] == LOW_TAG);
      add_unit(u, -1);
    end
  endtask

  // Most strings close with a quote; the rest end in each kind of failure.
  task automatic add_closing();
    int          pick;
    int          k;
    logic [7:0]  b;
    logic [15:0] u;
    pick = $urandom_range(99);
    if (pick < 66) begin
      add_byte(CH_QUOTE);
    end else if (pick < 71) begin
      add_end();
    end else if (pick < 76) begin
      add_byte(8'($urandom_range(8'h1F)));
    end else if (pick < 81) begin
      do b = 8'($urandom_range(255)); while (known_escape(b));
      add_byte(CH_BSLASH);
      add_byte(b);
    end else if (pick < 87) begin
      if ($urandom_range(1)) add_unit(rand_high(), -1);
      add_unit(16'($urandom_range(16'hFFFF)), int'($urandom_range(3)));
    end else if (pick < 90) begin
      if ($urandom_range(1)) add_unit(rand_high(), -1);
      add_byte(CH_BSLASH);
      add_end();
    end else if (pick < 94) begin
      if ($urandom_range(1)) add_unit(rand_high(), -1);
      u = 16'($urandom_range(16'hFFFF));
      add_byte(CH_BSLASH);
      add_byte(CH_U);
      k = $urandom_range(3);
      for (int i = 0; i < k; i++) add_byte(hex_char(u[4*i +: 4]));
      add_end();
    end else if (pick < 97) begin
      add_unit(rand_high(), -1);
      add_end();
    end else begin
      add_unit(rand_high(), -1);
      add_byte(CH_QUOTE);                // replacement, then done
    end
  endtask

  task automatic build_string();
    int n;
    if ($urandom_range(9) == 0) begin
      // raw noise: any byte, the odd end item
      n = $urandom_range(8, 1);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(11) == 0) add_end();
        else add_byte(8'($urandom_range(255)));
      end
    end else begin
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) add_body_token();
      add_closing();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // Idling mix by progress: receiver-heavy stalls, then sender-heavy gaps, then none.
  task automatic pick_idle_mix();
    if (sent < N_ITEMS / 3) begin
      src_idle  = 37;
      sink_idle = 53;
    end else if (sent < 2 * N_ITEMS / 3) begin
      src_idle  = 53;
      sink_idle = 37;
    end else begin
      src_idle  = 0;
      sink_idle = 0;
    end
  endtask

  // Called and returns at a falling edge; one transfer per call.
  task automatic push_item(input logic [8:0] item);
    pick_idle_mix();
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_byte   <= item[7:0];
    in_is_end <= item[8];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_text();
    while (text_q.size() > 0) push_item(text_q.pop_front());
  endtask

  task automatic load_directed();
    add_byte(8'h20);                  // lowest plain byte
    add_byte(8'hFF);                  // highest plain byte
    add_byte(CH_BSLASH);
    add_byte("n");
    add_byte(CH_BSLASH);
    add_byte(CH_QUOTE);
    add_unit(16'h00E9, -1);           // two-byte UTF-8
    add_byte(CH_QUOTE);               // done
    add_byte(8'h00);                  // control character error
    add_byte(CH_BSLASH);
    add_byte("q");                    // unknown escape
    add_unit(16'hD83D, -1);
    add_byte("A");                    // lone high surrogate, then plain A
    add_byte(8'h1F);                  // highest control character
    add_byte(CH_BSLASH);
    add_end();                        // end right after backslash
    add_end();                        // end in plain text
  endtask

  initial begin
    in_valid  = 1'b0;
    in_byte   = 8'h00;
    in_is_end = 1'b0;
    out_ready = 1'b0;
    rst_n     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    load_directed();
    send_text();
    while (sent < N_ITEMS) begin
      build_string();
      send_text();
    end
    in_valid <= 1'b0;

    // drain: wait for all owed results, then watch for strays
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input transfers: directed cases, then random strings under",
             sent);
    $display("three idling mixes; %0d results, %0d strings closed, %0d errors.",
             results_seen, strings_closed, errors_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
